// ----- rtl/ddcu_pkg.sv -----
// ----------------------------------------------------------------------------
// ddcu_pkg
// Types, constants and saturating fixed-point helpers shared by the drift and
// diffusion cell update pipeline.
// ----------------------------------------------------------------------------
package ddcu_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int RW = 31;
    localparam int CFG_IDX_W = 3;
    localparam int PIPE_LAT = 17;

    typedef logic signed [DW-1:0] dat_t;
    typedef logic [RW-1:0] ureg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP     = 3'd0,
        CFG_MOBILITY      = 3'd1,
        CFG_DIFFUSION     = 3'd2,
        CFG_GRID_STEP     = 3'd3,
        CFG_INV_GRID_STEP = 3'd4
    } cfg_idx_t;

    localparam dat_t DMAX = dat_t'({1'b0, {(DW-1){1'b1}}});
    localparam dat_t DMIN = dat_t'({1'b1, {(DW-1){1'b0}}});
    localparam dat_t SIX_TENTHS = dat_t'(((64'(6) << FB) + 64'(5)) / 64'(10));
    localparam dat_t FOUR_THIRDS = dat_t'(((64'(4) << FB) + 64'(1)) / 64'(3));

    localparam ureg_t RST_TIME_STEP = '0;
    localparam ureg_t RST_MOBILITY = ureg_t'(((64'(1) << FB) + 64'(500)) / 64'(1000));
    localparam ureg_t RST_DIFFUSION = ureg_t'(((64'(1) << FB) + 64'(5)) / 64'(10));
    localparam ureg_t RST_GRID_STEP = ureg_t'(64'(1) << FB);
    localparam ureg_t RST_INV_GRID_STEP = ureg_t'(64'(1) << FB);

    function automatic dat_t uext(ureg_t x);
        return dat_t'({1'b0, x});
    endfunction

    function automatic dat_t sadd(dat_t a, dat_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? DMIN : DMAX;
        return dat_t'(s[DW-1:0]);
    endfunction

    function automatic dat_t ssub(dat_t a, dat_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1])
            return s[DW] ? DMIN : DMAX;
        return dat_t'(s[DW-1:0]);
    endfunction

    function automatic dat_t sneg(dat_t x);
        return (x == DMIN) ? DMAX : dat_t'(-x);
    endfunction

    function automatic dat_t sabs(dat_t x);
        return x[DW-1] ? sneg(x) : x;
    endfunction

    function automatic dat_t half(dat_t x);
        return dat_t'(x / 2);
    endfunction

    // Product truncated toward zero and saturated.
    function automatic dat_t qmul(dat_t a, dat_t b);
        logic [DW-1:0]   ua;
        logic [DW-1:0]   ub;
        logic [2*DW-1:0] prod;
        logic [2*DW-1:0] mag;
        logic [2*DW-1:0] lim;
        logic            neg;
        dat_t            r;
        ua = a[DW-1] ? (~a + 1'b1) : a;
        ub = b[DW-1] ? (~b + 1'b1) : b;
        prod = ua * ub;
        mag = prod >> FB;
        neg = a[DW-1] ^ b[DW-1];
        lim = (2*DW)'(1) << (DW-1);
        if (!neg)
            lim = lim - 1'b1;
        if (mag > lim)
            mag = lim;
        r = dat_t'(mag[DW-1:0]);
        if (neg)
            r = dat_t'(-r);
        return r;
    endfunction

endpackage

// ----- rtl/uno3_drift_diffusion_cell_update.sv -----
// ----------------------------------------------------------------------------
// uno3_drift_diffusion_cell_update
// Computes the west and east face fluxes of one grid cell and its updated
// density in a seventeen-stage pipeline.
//
//   Channel  Handshake            Payload
//   in       in_valid, in_stall   window, face fields, areas, inv_volume, flags
//   out      out_valid, out_stall new_density, west_flux, east_flux
//   cfg      cfg_wr_en            cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low; the depth is set by the
// chain of dependent multipliers in the face flux and the density update.
// Reset clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module uno3_drift_diffusion_cell_update
    import ddcu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dat_t                 dens_far_west,
    input  dat_t                 dens_west,
    input  dat_t                 dens_center,
    input  dat_t                 dens_east,
    input  dat_t                 dens_far_east,
    input  dat_t                 field_west_face,
    input  dat_t                 field_east_face,
    input  ureg_t                area_west,
    input  ureg_t                area_east,
    input  ureg_t                inv_volume,
    input  logic                 is_first,
    input  logic                 is_last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dat_t                 new_density,
    output dat_t                 west_flux,
    output dat_t                 east_flux,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  ureg_t                cfg_data
);

    ureg_t time_step_reg;
    ureg_t mobility_reg;
    ureg_t diffusion_reg;
    ureg_t grid_step_reg;
    ureg_t inv_grid_step_reg;

    logic valid_reg [1:PIPE_LAT];
    logic en;

    dat_t c_reg [1:16];
    dat_t iv_reg [1:14];
    logic first_reg [1:PIPE_LAT];
    logic last_reg [1:PIPE_LAT];
    dat_t wf_reg [14:PIPE_LAT];
    dat_t ef_reg [14:PIPE_LAT];
    dat_t dflux_reg;
    dat_t q_reg;
    dat_t delta_reg;
    dat_t nd_reg;

    dat_t flux_w;
    dat_t flux_e;
    dat_t wsel_next;
    dat_t esel_next;

    assign en = !(valid_reg[PIPE_LAT] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= RST_TIME_STEP;
            mobility_reg <= RST_MOBILITY;
            diffusion_reg <= RST_DIFFUSION;
            grid_step_reg <= RST_GRID_STEP;
            inv_grid_step_reg <= RST_INV_GRID_STEP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP:     time_step_reg <= cfg_data;
                CFG_MOBILITY:      mobility_reg <= cfg_data;
                CFG_DIFFUSION:     diffusion_reg <= cfg_data;
                CFG_GRID_STEP:     grid_step_reg <= cfg_data;
                CFG_INV_GRID_STEP: inv_grid_step_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PIPE_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[1] <= in_valid;
            for (int i = 2; i <= PIPE_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    ddcu_face u_west (
        .clk           (clk),
        .en            (en),
        .dens_ll       (dens_far_west),
        .dens_l        (dens_west),
        .dens_r        (dens_center),
        .dens_rr       (dens_east),
        .field         (field_west_face),
        .area          (area_west),
        .time_step     (time_step_reg),
        .mobility      (mobility_reg),
        .diffusion     (diffusion_reg),
        .grid_step     (grid_step_reg),
        .inv_grid_step (inv_grid_step_reg),
        .flux          (flux_w)
    );

    ddcu_face u_east (
        .clk           (clk),
        .en            (en),
        .dens_ll       (dens_west),
        .dens_l        (dens_center),
        .dens_r        (dens_east),
        .dens_rr       (dens_far_east),
        .field         (field_east_face),
        .area          (area_east),
        .time_step     (time_step_reg),
        .mobility      (mobility_reg),
        .diffusion     (diffusion_reg),
        .grid_step     (grid_step_reg),
        .inv_grid_step (inv_grid_step_reg),
        .flux          (flux_e)
    );

    assign wsel_next = first_reg[13] ? '0 : flux_w;
    assign esel_next = last_reg[13] ? '0 : flux_e;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[1] <= dens_center;
            iv_reg[1] <= uext(inv_volume);
            first_reg[1] <= is_first;
            last_reg[1] <= is_last;
            for (int i = 2; i <= 16; i++)
                c_reg[i] <= c_reg[i-1];
            for (int i = 2; i <= 14; i++)
                iv_reg[i] <= iv_reg[i-1];
            for (int i = 2; i <= PIPE_LAT; i++)
            begin
                first_reg[i] <= first_reg[i-1];
                last_reg[i] <= last_reg[i-1];
            end

            wf_reg[14] <= wsel_next;
            ef_reg[14] <= esel_next;
            for (int i = 15; i <= PIPE_LAT; i++)
            begin
                wf_reg[i] <= wf_reg[i-1];
                ef_reg[i] <= ef_reg[i-1];
            end

            dflux_reg <= ssub(wsel_next, esel_next);
            q_reg <= qmul(dflux_reg, iv_reg[14]);
            delta_reg <= qmul(uext(time_step_reg), q_reg);
            nd_reg <= sadd(c_reg[16], delta_reg);
        end
    end

    assign out_valid = valid_reg[PIPE_LAT];
    assign new_density = nd_reg;
    assign west_flux = wf_reg[PIPE_LAT];
    assign east_flux = ef_reg[PIPE_LAT];

    // The input side is held exactly when a finished result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    // A waiting result keeps the pipeline frozen; checked on the first and ninth valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(valid_reg[1]) && $stable(valid_reg[9])))
        else $error("pipeline advanced while the result was stalled");

    // The first cell of a row has no west flux.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_reg[PIPE_LAT]) |-> (west_flux == '0))
        else $error("west flux not zero on first cell");

    // The last cell of a row has no east flux.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_reg[PIPE_LAT]) |-> (east_flux == '0))
        else $error("east flux not zero on last cell");

endmodule

// ----- rtl/ddcu_face.sv -----
// ----------------------------------------------------------------------------
// ddcu_face
// Thirteen-stage pipeline that computes the drift plus diffusion flux through
// one cell face with an upwind UNO3 limited donor density.
// ----------------------------------------------------------------------------
module ddcu_face
    import ddcu_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  dat_t  dens_ll,
    input  dat_t  dens_l,
    input  dat_t  dens_r,
    input  dat_t  dens_rr,
    input  dat_t  field,
    input  ureg_t area,
    input  ureg_t time_step,
    input  ureg_t mobility,
    input  ureg_t diffusion,
    input  ureg_t grid_step,
    input  ureg_t inv_grid_step,
    output dat_t  flux
);

    dat_t dt;
    dat_t mu;
    dat_t de;
    dat_t dz;
    dat_t ig;

    dat_t u_raw_reg;
    dat_t da_reg;
    dat_t db_reg;
    dat_t dg_reg;
    dat_t donor_reg [1:9];
    dat_t area_reg [1:12];
    dat_t u_reg [2:10];
    dat_t gdc_reg [2:7];
    dat_t gcu_reg [2:3];
    dat_t gg_reg;
    dat_t dif_reg [3:11];
    dat_t tp_reg;
    dat_t sum_reg;
    dat_t dl_reg;
    dat_t t1_reg [4:8];
    dat_t rhs_reg;
    dat_t kp_reg;
    dat_t adl_reg;
    dat_t mlim_reg [4:7];
    logic smooth_reg [5:7];
    dat_t w_reg;
    dat_t k_reg [5:6];
    dat_t fw_reg;
    dat_t p_reg;
    dat_t gc_reg;
    dat_t cp_reg;
    dat_t mf_reg;
    dat_t dr_reg;
    dat_t fd_reg;
    dat_t flux_reg;

    dat_t mlim_next;
    dat_t w_next;
    dat_t corr_next;

    assign dt = uext(time_step);
    assign mu = uext(mobility);
    assign de = uext(diffusion);
    assign dz = uext(grid_step);
    assign ig = uext(inv_grid_step);

    always_comb
    begin
        dat_t ad;
        dat_t ac;
        dat_t m;
        ad = sabs(gdc_reg[3]);
        ac = sabs(gcu_reg[3]);
        m = (ad < ac) ? ad : ac;
        if (gdc_reg[3] != '0 && gcu_reg[3] != '0 && gdc_reg[3][DW-1] == gcu_reg[3][DW-1])
            m = sadd(m, m);
        if (gdc_reg[3][DW-1])
            mlim_next = sneg(m);
        else if (gdc_reg[3] != '0)
            mlim_next = m;
        else
            mlim_next = '0;
    end

    always_comb
    begin
        if (u_reg[4][DW-1])
            w_next = sadd(dz, half(t1_reg[4]));
        else if (u_reg[4] != '0)
            w_next = ssub(dz, half(t1_reg[4]));
        else
            w_next = dz;
    end

    always_comb
    begin
        if (u_reg[9][DW-1])
            corr_next = sneg(half(cp_reg));
        else if (u_reg[9] != '0)
            corr_next = half(cp_reg);
        else
            corr_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_raw_reg <= qmul(mu, field);
            da_reg <= field[DW-1] ? ssub(dens_r, dens_l) : ssub(dens_l, dens_r);
            db_reg <= field[DW-1] ? ssub(dens_l, dens_ll) : ssub(dens_r, dens_rr);
            dg_reg <= ssub(dens_r, dens_l);
            donor_reg[1] <= field[DW-1] ? dens_l : dens_r;
            area_reg[1] <= uext(area);

            u_reg[2] <= sneg(u_raw_reg);
            gdc_reg[2] <= qmul(da_reg, ig);
            gcu_reg[2] <= qmul(db_reg, ig);
            gg_reg <= qmul(dg_reg, ig);

            tp_reg <= qmul(sabs(u_reg[2]), dt);
            dif_reg[3] <= qmul(de, gg_reg);
            sum_reg <= sadd(gdc_reg[2], gcu_reg[2]);
            dl_reg <= ssub(gdc_reg[2], gcu_reg[2]);

            t1_reg[4] <= ssub(dz, tp_reg);
            rhs_reg <= qmul(SIX_TENTHS, sabs(sum_reg));
            kp_reg <= qmul(dl_reg, ig);
            adl_reg <= sabs(dl_reg);
            mlim_reg[4] <= mlim_next;

            smooth_reg[5] <= (adl_reg <= rhs_reg);
            w_reg <= w_next;
            k_reg[5] <= half(kp_reg);

            fw_reg <= qmul(FOUR_THIRDS, w_reg);
            p_reg <= qmul(fw_reg, k_reg[6]);
            gc_reg <= smooth_reg[7] ? ssub(gdc_reg[7], p_reg) : mlim_reg[7];
            cp_reg <= qmul(t1_reg[8], gc_reg);
            mf_reg <= sadd(donor_reg[9], corr_next);
            dr_reg <= qmul(mf_reg, u_reg[10]);
            fd_reg <= ssub(dr_reg, dif_reg[11]);
            flux_reg <= qmul(fd_reg, area_reg[12]);

            for (int i = 2; i <= 9; i++)
                donor_reg[i] <= donor_reg[i-1];
            for (int i = 2; i <= 12; i++)
                area_reg[i] <= area_reg[i-1];
            for (int i = 3; i <= 10; i++)
                u_reg[i] <= u_reg[i-1];
            for (int i = 3; i <= 7; i++)
                gdc_reg[i] <= gdc_reg[i-1];
            gcu_reg[3] <= gcu_reg[2];
            for (int i = 4; i <= 11; i++)
                dif_reg[i] <= dif_reg[i-1];
            for (int i = 5; i <= 8; i++)
                t1_reg[i] <= t1_reg[i-1];
            for (int i = 5; i <= 7; i++)
                mlim_reg[i] <= mlim_reg[i-1];
            for (int i = 6; i <= 7; i++)
                smooth_reg[i] <= smooth_reg[i-1];
            k_reg[6] <= k_reg[5];
        end
    end

    assign flux = flux_reg;

endmodule
